FILE: rtl/core/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types and codes for the triggered sample capture core.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int SAMPLE_W = 8;
  localparam int GAP_W    = 16;
  localparam int COUNT_W  = 8;
  localparam int CFG_W    = 16;

  // request kinds, carried on in_tuser
  typedef enum logic [1:0] {
    KIND_SAMPLE     = 2'd0,
    KIND_START      = 2'd1,
    KIND_START_SEND = 2'd2,
    KIND_STOP       = 2'd3
  } kind_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_TRIG_LEVEL = 1'b0,
    CFG_SAMPLE_GAP = 1'b1
  } cfg_idx_t;

  localparam logic [SAMPLE_W-1:0] TRIG_LEVEL_RST = 8'd128;
  localparam logic [GAP_W-1:0]    SAMPLE_GAP_RST = 16'd0;

  typedef struct packed {
    logic               running;
    logic               send_ready;
    logic               armed;
    logic               capturing;
    logic               sending_now;
    logic [COUNT_W-1:0] captured_count;
    logic [GAP_W-1:0]   skip_count;
  } tsc_state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] data;
    logic                last;
    logic                sent;
  } tsc_result_t;

endpackage

FILE: rtl/core/tsc_step.sv
// ----------------------------------------------------------------------------
// tsc_step
// Trigger and capture decision for one request: next state and optional result.
// ----------------------------------------------------------------------------
module tsc_step import tsc_pkg::*; #(
  parameter int CAPTURE_LEN = 200
) (
  input  tsc_state_t          st,
  input  logic [SAMPLE_W-1:0] trig_level,
  input  logic [GAP_W-1:0]    sample_gap,
  input  kind_t               kind,
  input  logic [SAMPLE_W-1:0] sample,
  output tsc_state_t          st_nxt,
  output logic                res_valid,
  output tsc_result_t         res
);

  localparam logic [COUNT_W-1:0] LEN = COUNT_W'(CAPTURE_LEN);

  logic [GAP_W-1:0]   skip_dec;
  logic [COUNT_W-1:0] cnt_inc;
  logic               is_final;

  assign skip_dec = st.skip_count - GAP_W'(1);
  assign cnt_inc  = st.captured_count + COUNT_W'(1);
  assign is_final = (cnt_inc >= LEN);

  always_comb begin
    st_nxt    = st;
    res_valid = 1'b0;
    res       = '0;
    unique case (kind)
      KIND_START, KIND_START_SEND: begin
        st_nxt.running = 1'b1;
        st_nxt.armed   = 1'b0;
        if (kind == KIND_START_SEND) begin
          st_nxt.send_ready = 1'b1;
        end
      end
      KIND_STOP: begin
        st_nxt.running = 1'b0;
        st_nxt.armed   = 1'b0;
      end
      default: begin
        if (st.capturing) begin
          if (st.skip_count != '0) begin
            st_nxt.skip_count = skip_dec;
            if (skip_dec == '0 && st.captured_count >= LEN) begin
              st_nxt.capturing      = 1'b0;
              st_nxt.sending_now    = 1'b0;
              st_nxt.captured_count = '0;
            end
          end else begin
            st_nxt.captured_count = cnt_inc;
            st_nxt.skip_count     = sample_gap;
            // end now when no trailing skips follow the final sample
            if (is_final && sample_gap == '0) begin
              st_nxt.capturing      = 1'b0;
              st_nxt.sending_now    = 1'b0;
              st_nxt.captured_count = '0;
              st_nxt.skip_count     = '0;
            end
            if (st.sending_now) begin
              res_valid = 1'b1;
              res.data  = sample;
              res.last  = is_final;
              res.sent  = 1'b1;
            end else if (is_final) begin
              res_valid = 1'b1;
              res.last  = 1'b1;
            end
          end
        end else if (st.running) begin
          if (!st.armed) begin
            if (sample < trig_level) begin
              st_nxt.armed = 1'b1;
            end
          end else if (sample > trig_level) begin
            st_nxt.armed          = 1'b0;
            st_nxt.capturing      = 1'b1;
            st_nxt.sending_now    = st.send_ready;
            st_nxt.send_ready     = 1'b0;
            st_nxt.captured_count = '0;
            st_nxt.skip_count     = '0;
          end else if (sample == trig_level) begin
            st_nxt.armed = 1'b0;
          end
        end
      end
    endcase
  end

endmodule

FILE: rtl/core/triggered_sample_capture_core.sv
// ----------------------------------------------------------------------------
// triggered_sample_capture_core
// Rising-edge trigger on an 8-bit sample stream with gapped capture output.
// ----------------------------------------------------------------------------
// A request waits in the input register; its result goes to the output register.
// Throughput: one request per cycle; the input register drains whenever the
//   request makes no result or the output register is free or being taken.
// Reset (rst_n low, synchronous): both registers empty, trigger level 128,
//   gap 0, stopped, send enabled, no capture in progress.
module triggered_sample_capture_core import tsc_pkg::*; #(
  parameter int CAPTURE_LEN = 200
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] sample
  input  logic [1:0]          in_tuser,   // [1:0] kind
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,  // [7:0] data
  output logic                out_tlast,
  output logic                out_tuser,  // [0] sent
  input  logic                cfg_we,
  input  logic [0:0]          cfg_idx,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  logic                in_valid_r;
  kind_t               in_kind_r;
  logic [SAMPLE_W-1:0] in_sample_r;

  logic [SAMPLE_W-1:0] trig_level_r;
  logic [GAP_W-1:0]    sample_gap_r;

  tsc_state_t          st_r;
  tsc_state_t          st_nxt;
  logic                res_valid;
  tsc_result_t         res;

  logic                out_valid_r;
  tsc_result_t         out_res_r;

  logic                advance;

  tsc_step #(
    .CAPTURE_LEN (CAPTURE_LEN)
  ) u_step (
    .st         (st_r),
    .trig_level (trig_level_r),
    .sample_gap (sample_gap_r),
    .kind       (in_kind_r),
    .sample     (in_sample_r),
    .st_nxt     (st_nxt),
    .res_valid  (res_valid),
    .res        (res)
  );

  // hold a request only while its result has nowhere to go
  assign advance   = in_valid_r && (!res_valid || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      trig_level_r <= TRIG_LEVEL_RST;
      sample_gap_r <= SAMPLE_GAP_RST;
      st_r         <= '{running: 1'b0, send_ready: 1'b1, armed: 1'b0,
                        capturing: 1'b0, sending_now: 1'b0,
                        captured_count: '0, skip_count: '0};
      out_valid_r  <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        st_r <= st_nxt;
      end
      if (advance && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_idx))
          CFG_TRIG_LEVEL: trig_level_r <= cfg_wdata[SAMPLE_W-1:0];
          CFG_SAMPLE_GAP: sample_gap_r <= cfg_wdata[GAP_W-1:0];
          default:        ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_kind_r   <= kind_t'(in_tuser);
      in_sample_r <= in_tdata;
    end
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.data;
  assign out_tlast  = out_res_r.last;
  assign out_tuser  = out_res_r.sent;

endmodule
